>>> sv/bcpc_pkg.sv
// shared types, constants and arithmetic helpers for the pressure compensation block
`timescale 1ns / 1ps
package bcpc_pkg;

   localparam int RawW              = 20;
   localparam int CsrIdxW           = 3;
   localparam int CsrDataW          = 32;
   localparam int DivSteps          = 64;
   localparam int FrontStages       = 10;
   localparam int QueueDepthDefault = 2;

   localparam logic [32:0] FineOffset   = 33'd128000;
   localparam logic [20:0] PressFull    = 21'd1048576;
   localparam logic [31:0] PressScale   = 32'd3125;
   localparam int          DivBaseShift = 47;
   localparam int          P4Shift      = 35;
   localparam logic [31:0] TempRound    = 32'd128;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegTempOne      = 3'd0;
   localparam logic [CsrIdxW-1:0] RegTempTwo      = 3'd1;
   localparam logic [CsrIdxW-1:0] RegTempThree    = 3'd2;
   localparam logic [CsrIdxW-1:0] RegPressOne     = 3'd3;
   localparam logic [CsrIdxW-1:0] RegPressTwoThr  = 3'd4;
   localparam logic [CsrIdxW-1:0] RegPressFourFiv = 3'd5;
   localparam logic [CsrIdxW-1:0] RegPressSixSev  = 3'd6;
   localparam logic [CsrIdxW-1:0] RegPressEigNin  = 3'd7;

   typedef struct packed {
      logic [RawW-1:0] raw_temperature;
      logic [RawW-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic [31:0] fine_temperature;
      logic [23:0] temperature_centi;
      logic [31:0] pressure_q24_8;
      logic        pressure_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   // one queued item: temperature results plus division operands
   typedef struct packed {
      logic [31:0] fine;
      logic [23:0] centi;
      logic [63:0] dividend;
      logic [30:0] divisor;
   } work_type;

   // unsigned 32 times signed 16, full signed product
   function automatic logic [48:0] mul_lo_s16(input logic [31:0] a, input logic [15:0] b);
      logic signed [48:0] r;
      r = $signed({1'b0, a}) * $signed(b);
      return r;
   endfunction

   // low 32 bits of a times sign-extended b
   function automatic logic [31:0] mul_hi_s16(input logic [31:0] a, input logic [15:0] b);
      logic [31:0] bx;
      bx = {{16{b[15]}}, b};
      return a * bx;
   endfunction

   function automatic logic [63:0] sx64_16(input logic [15:0] b);
      return {{48{b[15]}}, b};
   endfunction

   function automatic logic [63:0] sx64_49(input logic [48:0] b);
      return {{15{b[48]}}, b};
   endfunction

endpackage

>>> sv/baro_temp_pressure_compensation_unit.sv
// top level: coefficient registers, front pipeline, queue and back pipeline
`timescale 1ns / 1ps
// Integer temperature and pressure compensation for a barometric sensor. A reading
// pair is taken when start is high and busy is low; one can be taken every clock.
// Each beat yields one result, strobed on rsp_valid for a single cycle; the
// receiver has no way to hold it, so it must capture it then. The back pipeline
// holds the 64-stage restoring divider (one quotient bit per stage), after 10 front
// stages for the temperature and operand math; further stages do queueing, sign
// fix-up and final correction. Coefficients are to be written through the csr port
// only while no reading is in flight; the block itself does not enforce this.
// A zero divisor gives pressure 0 with pressure_valid low.
module baro_temp_pressure_compensation_unit import bcpc_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   coeff_type coeff_ff;
   logic      accept, front_valid, queue_valid, queue_full;
   work_type  front_beat, queue_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            RegTempOne:      coeff_ff.t1 <= csr_wdata[15:0];
            RegTempTwo:      coeff_ff.t2 <= csr_wdata[15:0];
            RegTempThree:    coeff_ff.t3 <= csr_wdata[15:0];
            RegPressOne:     coeff_ff.p1 <= csr_wdata[15:0];
            RegPressTwoThr:  {coeff_ff.p3, coeff_ff.p2} <= csr_wdata;
            RegPressFourFiv: {coeff_ff.p5, coeff_ff.p4} <= csr_wdata;
            RegPressSixSev:  {coeff_ff.p7, coeff_ff.p6} <= csr_wdata;
            RegPressEigNin:  {coeff_ff.p9, coeff_ff.p8} <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy   = queue_full;
   assign accept = start && !busy;

   bcpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_beat   (req_data),
      .coeff     (coeff_ff),
      .out_valid (front_valid),
      .out_beat  (front_beat)
   );

   bcpc_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_beat (front_beat),
      .pop_valid (queue_valid),
      .pop_beat  (queue_beat),
      .full      (queue_full)
   );

   bcpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_beat   (queue_beat),
      .coeff     (coeff_ff),
      .out_valid (rsp_valid),
      .out_beat  (rsp_data)
   );

endmodule

>>> sv/bcpc_front.sv
// front pipeline: temperature compensation and division operand preparation
`timescale 1ns / 1ps
module bcpc_front import bcpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_beat,
   input  coeff_type coeff,
   output logic      out_valid,
   output work_type  out_beat
);

   logic [FrontStages-1:0] vld_ff;

   logic [RawW-1:0] raw_t_ff;
   logic [RawW-1:0] rawp_ff [0:7];
   logic [31:0] xt2_ff, dsq_ff, tv1_ff, m_ff;
   logic [31:0] fine_ff [0:5];
   logic [23:0] centi_ff [0:4];
   logic [63:0] sq_ff;
   logic [48:0] v1p5_ff, v1p2_ff, v1p5_d_ff, v1p2_d_ff, v1p5_e_ff, v1p2_e_ff;
   logic [48:0] pp6lo_ff, pp3lo_ff;
   logic [31:0] pp6hi_ff, pp3hi_ff;
   logic [63:0] sqp6_ff, sqp3_ff, v2_ff, base_ff;
   logic [47:0] blo_ff;
   logic [31:0] bhi_ff, nhi_ff;
   logic [43:0] nlo_ff;
   work_type    out_ff;

   logic [31:0] x_in, d_in, t2x, t3x, dsh, cen_in, av_in;
   logic [32:0] v1_in;
   logic [63:0] v2_in, base_in, num_in, prod_in;
   logic [20:0] pdiff_in;

   always_comb begin
      x_in     = {15'b0, raw_t_ff[19:3]} - {15'b0, coeff.t1, 1'b0};
      d_in     = {16'b0, raw_t_ff[19:4]} - {16'b0, coeff.t1};
      t2x      = {{16{coeff.t2[15]}}, coeff.t2};
      t3x      = {{16{coeff.t3[15]}}, coeff.t3};
      dsh      = 32'($signed(dsq_ff) >>> 12);
      v1_in    = {fine_ff[0][31], fine_ff[0]} - FineOffset;
      av_in    = v1_in[32] ? 32'(~v1_in + 33'd1) : v1_in[31:0];
      cen_in   = fine_ff[0] + {fine_ff[0][29:0], 2'b0} + TempRound;
      v2_in    = sqp6_ff + (sx64_49(v1p5_e_ff) << 17) + (sx64_16(coeff.p4) << P4Shift);
      base_in  = 64'($signed(sqp3_ff) >>> 8) + (sx64_49(v1p2_e_ff) << 12)
                 + (64'd1 << DivBaseShift);
      pdiff_in = PressFull - {1'b0, rawp_ff[7]};
      num_in   = ({43'b0, pdiff_in} << 31) - v2_ff;
      prod_in  = {16'b0, blo_ff} + {bhi_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FrontStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      raw_t_ff   <= in_beat.raw_temperature;
      rawp_ff[0] <= in_beat.raw_pressure;
      for (int i = 1; i < 8; i++) begin
         rawp_ff[i] <= rawp_ff[i-1];
      end
      // temperature, 32-bit wrapping
      xt2_ff      <= x_in * t2x;
      dsq_ff      <= d_in * d_in;
      tv1_ff      <= 32'($signed(xt2_ff) >>> 11);
      m_ff        <= dsh * t3x;
      fine_ff[0]  <= tv1_ff + 32'($signed(m_ff) >>> 14);
      for (int i = 1; i < 6; i++) begin
         fine_ff[i] <= fine_ff[i-1];
      end
      centi_ff[0] <= cen_in[31:8];
      for (int i = 1; i < 5; i++) begin
         centi_ff[i] <= centi_ff[i-1];
      end
      // pressure operands, 64-bit wrapping
      sq_ff     <= av_in * av_in;
      v1p5_ff   <= 49'($signed(v1_in) * $signed(coeff.p5));
      v1p2_ff   <= 49'($signed(v1_in) * $signed(coeff.p2));
      pp6lo_ff  <= mul_lo_s16(sq_ff[31:0], coeff.p6);
      pp6hi_ff  <= mul_hi_s16(sq_ff[63:32], coeff.p6);
      pp3lo_ff  <= mul_lo_s16(sq_ff[31:0], coeff.p3);
      pp3hi_ff  <= mul_hi_s16(sq_ff[63:32], coeff.p3);
      v1p5_d_ff <= v1p5_ff;
      v1p2_d_ff <= v1p2_ff;
      sqp6_ff   <= sx64_49(pp6lo_ff) + {pp6hi_ff, 32'b0};
      sqp3_ff   <= sx64_49(pp3lo_ff) + {pp3hi_ff, 32'b0};
      v1p5_e_ff <= v1p5_d_ff;
      v1p2_e_ff <= v1p2_d_ff;
      v2_ff     <= v2_in;
      base_ff   <= base_in;
      blo_ff    <= base_ff[31:0] * coeff.p1;
      bhi_ff    <= base_ff[63:32] * {16'b0, coeff.p1};
      nlo_ff    <= 44'(num_in[31:0] * PressScale);
      nhi_ff    <= num_in[63:32] * PressScale;
      out_ff.fine     <= fine_ff[5];
      out_ff.centi    <= centi_ff[4];
      out_ff.dividend <= {20'b0, nlo_ff} + {nhi_ff, 32'b0};
      out_ff.divisor  <= prod_in[63:33];
   end

   assign out_valid = vld_ff[FrontStages-1];
   assign out_beat  = out_ff;

endmodule

>>> sv/bcpc_queue.sv
// short queue between the front and back pipelines
`timescale 1ns / 1ps
module bcpc_queue import bcpc_pkg::*; #(
   parameter int Depth = QueueDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_beat,
   output logic     pop_valid,
   output work_type pop_beat,
   output logic     full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   work_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   // back end never stalls, so the head leaves as soon as it is there
   assign pop       = (count_ff != '0);
   assign pop_valid = pop;
   assign pop_beat  = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == CntW'(Depth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && (count_ff == '0) |=> (count_ff != '0))
      else $error("beat pushed into empty queue was lost");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into full queue");
`endif

endmodule

>>> sv/bcpc_back.sv
// back pipeline: signed 64-bit divider and final pressure correction
`timescale 1ns / 1ps
module bcpc_back import bcpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  work_type  in_beat,
   input  coeff_type coeff,
   output logic      out_valid,
   output rsp_type   out_beat
);

   typedef struct packed {
      logic [31:0] fine;
      logic [23:0] centi;
      logic [30:0] divisor_mag;
      logic        neg;
      logic        zero;
   } div_side_type;

   typedef struct packed {
      logic [31:0] fine;
      logic [23:0] centi;
      logic        zero;
   } post_side_type;

   logic [DivSteps:0] div_vld_ff;
   logic [6:0]        post_vld_ff;
   div_side_type      side_ff [0:DivSteps];
   logic [30:0]       rem_ff  [0:DivSteps];
   logic [DivSteps-1:0] aq_ff [0:DivSteps];
   post_side_type     ps_ff   [0:5];

   logic [63:0] q_ff, q_d_ff, q_e_ff, q_f_ff, lolo_ff, phsq_ff, p8q_ff, v2_ff, sum_ff, pr_ff;
   logic [31:0] lohi_ff, p8hi_ff, p9hi_ff;
   logic [48:0] p8lo_ff, p9lo_ff;
   rsp_type     out_ff;
   logic        out_vld_ff;

   logic [63:0] ua_in, ph_in, v1_in;
   logic [30:0] ub_in;

   always_comb begin
      ua_in = in_beat.dividend[63] ? (~in_beat.dividend + 64'd1) : in_beat.dividend;
      ub_in = in_beat.divisor[30] ? (~in_beat.divisor + 31'd1) : in_beat.divisor;
      ph_in = 64'($signed(q_ff) >>> 13);
      v1_in = 64'($signed(sx64_49(p9lo_ff) + {p9hi_ff, 32'b0}) >>> 25);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff  <= '0;
         post_vld_ff <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         div_vld_ff  <= {div_vld_ff[DivSteps-1:0], in_valid};
         post_vld_ff <= {post_vld_ff[5:0], div_vld_ff[DivSteps]};
         out_vld_ff  <= post_vld_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0].fine        <= in_beat.fine;
      side_ff[0].centi       <= in_beat.centi;
      side_ff[0].divisor_mag <= ub_in;
      side_ff[0].neg         <= in_beat.dividend[63] ^ in_beat.divisor[30];
      side_ff[0].zero        <= (in_beat.divisor == '0);
      rem_ff[0]              <= '0;
      aq_ff[0]               <= ua_in;
   end

   // one quotient bit per stage, dividend shifts out as quotient shifts in
   for (genvar gi = 0; gi < DivSteps; gi++) begin : g_div
      logic [31:0] trial;
      logic        fit;
      assign trial = {rem_ff[gi], aq_ff[gi][DivSteps-1]};
      assign fit   = (trial >= {1'b0, side_ff[gi].divisor_mag});
      always_ff @(posedge clock) begin
         side_ff[gi+1] <= side_ff[gi];
         aq_ff[gi+1]   <= {aq_ff[gi][DivSteps-2:0], fit};
         if (fit) begin
            rem_ff[gi+1] <= 31'(trial - {1'b0, side_ff[gi].divisor_mag});
         end else begin
            rem_ff[gi+1] <= trial[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= side_ff[DivSteps].neg ? (~aq_ff[DivSteps] + 64'd1) : aq_ff[DivSteps];
      ps_ff[0].fine  <= side_ff[DivSteps].fine;
      ps_ff[0].centi <= side_ff[DivSteps].centi;
      ps_ff[0].zero  <= side_ff[DivSteps].zero;
      for (int i = 1; i < 6; i++) begin
         ps_ff[i] <= ps_ff[i-1];
      end
      lolo_ff <= ph_in[31:0] * ph_in[31:0];
      lohi_ff <= ph_in[31:0] * ph_in[63:32];
      p8lo_ff <= mul_lo_s16(q_ff[31:0], coeff.p8);
      p8hi_ff <= mul_hi_s16(q_ff[63:32], coeff.p8);
      q_d_ff  <= q_ff;
      phsq_ff <= lolo_ff + {lohi_ff[30:0], 33'b0};
      p8q_ff  <= sx64_49(p8lo_ff) + {p8hi_ff, 32'b0};
      q_e_ff  <= q_d_ff;
      p9lo_ff <= mul_lo_s16(phsq_ff[31:0], coeff.p9);
      p9hi_ff <= mul_hi_s16(phsq_ff[63:32], coeff.p9);
      v2_ff   <= 64'($signed(p8q_ff) >>> 19);
      q_f_ff  <= q_e_ff;
      sum_ff  <= q_f_ff + v1_in + v2_ff;
      pr_ff   <= 64'($signed(sum_ff) >>> 8) + (sx64_16(coeff.p7) << 4);
      out_ff.fine_temperature  <= ps_ff[5].fine;
      out_ff.temperature_centi <= ps_ff[5].centi;
      out_ff.pressure_valid    <= !ps_ff[5].zero;
      if (ps_ff[5].zero || pr_ff[63]) begin
         out_ff.pressure_q24_8 <= '0;
      end else if (pr_ff[62:32] != '0) begin
         out_ff.pressure_q24_8 <= '1;
      end else begin
         out_ff.pressure_q24_8 <= pr_ff[31:0];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_beat  = out_ff;

`ifndef SYNTHESIS
   a_zero_div_clear: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.pressure_valid |-> out_ff.pressure_q24_8 == '0)
      else $error("pressure nonzero after zero divisor");
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[DivSteps] |-> $past(div_vld_ff[0], DivSteps))
      else $error("divider beat without matching entry");
   a_out_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(div_vld_ff[DivSteps], 7))
      else $error("result strobe without divider beat");
`endif

endmodule

>>> sim/tb_baro_temp_pressure_compensation_unit.sv
// testbench for the barometric temperature and pressure compensation unit
`timescale 1ns / 1ps
module tb_baro_temp_pressure_compensation_unit;
   import bcpc_pkg::*;

   class compensation_scoreboard;
      logic [31:0] coeff_regs [8];
      rsp_type     expected_q [$];
      int          errors;

      function new();
         errors = 0;
         foreach (coeff_regs[i]) coeff_regs[i] = '0;
      endfunction

      function logic [31:0] asr32(logic [31:0] v, int n);
         logic signed [31:0] s;
         s = v;
         s = s >>> n;
         return s;
      endfunction

      function logic [63:0] asr64(logic [63:0] v, int n);
         logic signed [63:0] s;
         s = v;
         s = s >>> n;
         return s;
      endfunction

      function logic [63:0] sext16(logic [15:0] v);
         return {{48{v[15]}}, v};
      endfunction

      function rsp_type compensate(req_type r);
         rsp_type     o;
         logic [31:0] adc_t, t1, t2, t3, x, d, tv1, tv2, fine;
         logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [63:0] v1, v2, p, ph, num, den, ua, ub, q;
         adc_t = {12'b0, r.raw_temperature};
         t1 = {16'b0, coeff_regs[0][15:0]};
         t2 = {{16{coeff_regs[1][15]}}, coeff_regs[1][15:0]};
         t3 = {{16{coeff_regs[2][15]}}, coeff_regs[2][15:0]};
         p1 = {48'b0, coeff_regs[3][15:0]};
         p2 = sext16(coeff_regs[4][15:0]);
         p3 = sext16(coeff_regs[4][31:16]);
         p4 = sext16(coeff_regs[5][15:0]);
         p5 = sext16(coeff_regs[5][31:16]);
         p6 = sext16(coeff_regs[6][15:0]);
         p7 = sext16(coeff_regs[6][31:16]);
         p8 = sext16(coeff_regs[7][15:0]);
         p9 = sext16(coeff_regs[7][31:16]);

         // temperature, everything wraps at 32 bits
         x = (adc_t >> 3) - (t1 << 1);
         tv1 = asr32(x * t2, 11);
         d = (adc_t >> 4) - t1;
         tv2 = asr32(asr32(d * d, 12) * t3, 14);
         fine = tv1 + tv2;
         o.fine_temperature = fine;
         o.temperature_centi = 24'(asr32(fine * 32'd5 + 32'd128, 8));

         // pressure, everything wraps at 64 bits
         v1 = {{32{fine[31]}}, fine} - 64'd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) << 17);
         v2 = v2 + (p4 << 35);
         v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
         v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
         if (v1 == 0) begin
            o.pressure_q24_8 = '0;
            o.pressure_valid = 1'b0;
         end else begin
            p = 64'd1048576 - {44'b0, r.raw_pressure};
            num = ((p << 31) - v2) * 64'd3125;
            den = v1;
            // truncating signed divide, min / -1 wraps to itself
            ua = num[63] ? -num : num;
            ub = den[63] ? -den : den;
            q = ua / ub;
            p = (num[63] != den[63]) ? -q : q;
            ph = asr64(p, 13);
            v1 = asr64(p9 * ph * ph, 25);
            v2 = asr64(p8 * p, 19);
            p = asr64(p + v1 + v2, 8) + (p7 << 4);
            if (p[63]) o.pressure_q24_8 = '0;
            else if (p[63:32] != 0) o.pressure_q24_8 = 32'hFFFF_FFFF;
            else o.pressure_q24_8 = p[31:0];
            o.pressure_valid = 1'b1;
         end
         return o;
      endfunction

      function void note_reading(req_type r);
         expected_q.push_back(compensate(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.fine_temperature !== e.fine_temperature) begin
            $display("%0t: fine_temperature exp %h got %h", $time,
                     e.fine_temperature, got.fine_temperature);
            errors++;
         end
         if (got.temperature_centi !== e.temperature_centi) begin
            $display("%0t: temperature_centi exp %h got %h", $time,
                     e.temperature_centi, got.temperature_centi);
            errors++;
         end
         if (got.pressure_q24_8 !== e.pressure_q24_8) begin
            $display("%0t: pressure_q24_8 exp %h got %h", $time,
                     e.pressure_q24_8, got.pressure_q24_8);
            errors++;
         end
         if (got.pressure_valid !== e.pressure_valid) begin
            $display("%0t: pressure_valid exp %b got %b", $time,
                     e.pressure_valid, got.pressure_valid);
            errors++;
         end
      endfunction
   endclass

   localparam int WatchLimit = 3000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   compensation_scoreboard sb = new();
   int idle_pct;
   int quiet_cycles;

   baro_temp_pressure_compensation_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_coeffs(input logic [31:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[CsrIdxW-1:0];
         csr_wdata <= vals[i];
         sb.coeff_regs[i] = (i < 4) ? {16'b0, vals[i][15:0]} : vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
      req_type r;
      r.raw_temperature = rt;
      r.raw_pressure = rp;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_reading(r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_readings(input int n);
      logic [19:0] rt, rp;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) idle_pct = (i / 60 % 4 == 0) ? 0 : (i / 60 % 4 == 1) ? 64 : 36;
         if ($urandom_range(99) < 70) begin
            // plausible sensor range
            rt = 20'($urandom_range(600000, 380000));
            rp = 20'($urandom_range(600000, 200000));
         end else begin
            rt = 20'($urandom);
            rp = 20'($urandom);
         end
         send_reading(rt, rp);
      end
   endtask

   initial begin
      logic [31:0] cfg [8];
      logic [19:0] edge_vals [4];
      edge_vals = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
      idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all coefficients zero: divisor is zero, pressure forced invalid
      foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[3 - i]);
      drain();

      // typical calibration
      cfg = '{32'd27504, 32'd26435, 32'hFFFF_FC18, 32'd36477,
              {16'd3024, 16'hD643}, {16'd140, 16'd2855},
              {16'd15500, 16'hFFF9}, {16'd6000, 16'hC6F8}};
      write_coeffs(cfg);
      foreach (edge_vals[i]) foreach (edge_vals[j]) send_reading(edge_vals[i], edge_vals[j]);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'd519888, 20'd0);
      random_readings(300);
      drain();

      // all ones
      cfg = '{default: 32'hFFFF_FFFF};
      write_coeffs(cfg);
      foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[i]);
      random_readings(150);
      drain();

      // most negative signed coefficients, largest unsigned
      cfg = '{32'hFFFF, 32'h8000, 32'h8000, 32'hFFFF, 32'h8000_8000, 32'h8000_8000,
              32'h8000_8000, 32'h8000_8000};
      write_coeffs(cfg);
      foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[3 - i]);
      random_readings(150);
      drain();

      // most positive signed coefficients
      cfg = '{32'h0, 32'h7FFF, 32'h7FFF, 32'h1, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
              32'h7FFF_7FFF, 32'h7FFF_7FFF};
      write_coeffs(cfg);
      random_readings(150);
      drain();

      // random calibrations, some near typical
      for (int k = 0; k < 4; k++) begin
         foreach (cfg[i]) cfg[i] = $urandom;
         if (k % 2 == 0) begin
            cfg[0] = 27000 + $urandom_range(1000);
            cfg[3] = 36000 + $urandom_range(1000);
         end
         write_coeffs(cfg);
         random_readings(140);
         drain();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/bcpc_pkg.sv
sv/bcpc_front.sv
sv/bcpc_queue.sv
sv/bcpc_back.sv
sv/baro_temp_pressure_compensation_unit.sv
sim/tb_baro_temp_pressure_compensation_unit.sv
